// ===== rtl/mma_pkg.sv =====
package mma_pkg;

  localparam int NUM_CHANNELS_DEFAULT = 6;
  localparam int WINDOW_DEFAULT       = 8;

  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 18;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } in_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel_out;
    logic [SAMPLE_W-1:0]  average;
  } out_t;

  typedef struct packed {
    logic                 in_range;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } mid_t;

endpackage

// ===== rtl/mma_fifo.sv =====
module mma_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mma_front.sv =====
module mma_front #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mma_pkg::in_t      request,
  output mma_pkg::mid_t     mid_item,
  output logic              mid_valid,
  input  logic              mid_take
);

  import mma_pkg::*;

  mid_t classified;
  logic mid_empty;

  always_comb begin
    classified.in_range = (32'(request.channel) < NUM_CHANNELS);
    classified.channel  = request.channel;
    classified.sample   = request.sample;
  end

  mma_fifo #(
    .WIDTH($bits(mid_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(classified),
    .rd_en  (mid_take),
    .rd_data(mid_item),
    .full   (full),
    .empty  (mid_empty)
  );

  assign mid_valid = !mid_empty;

endmodule

// ===== rtl/mma_back.sv =====
module mma_back #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEFAULT,
  parameter int WINDOW       = mma_pkg::WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mma_pkg::mid_t     mid_item,
  input  logic              mid_valid,
  output logic              mid_take,
  input  logic              pop,
  output logic              empty,
  output mma_pkg::out_t     result
);

  import mma_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MEM_D    = NUM_CHANNELS * WINDOW;
  localparam int ADDR_W   = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int SHIFT    = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint RECIP_L = ((64'(1) << SHIFT) + 64'(WINDOW) - 64'(1)) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int OCC_W    = $clog2(OUT_DEPTH + 1);

  // ring store, per-channel ring pointers and sums
  logic [SAMPLE_W-1:0] mem [MEM_D];
  logic [POS_W-1:0]    pos [NUM_CHANNELS];
  logic                wrapped [NUM_CHANNELS];
  logic [SUM_W-1:0]    sum [NUM_CHANNELS];

  logic [OCC_W-1:0]    occ;
  logic                issue;
  logic [CH_IDX_W-1:0] a_idx;
  logic [POS_W-1:0]    a_pos;
  logic [ADDR_W-1:0]   a_addr;

  logic                b_valid;
  logic                b_in_range;
  logic                b_old_valid;
  logic [CHANNEL_W-1:0] b_ch;
  logic [SAMPLE_W-1:0] b_sample;
  logic [SAMPLE_W-1:0] b_rdata;
  logic [CH_IDX_W-1:0] b_idx;
  logic [SAMPLE_W-1:0] b_old;
  logic [SUM_W-1:0]    sum_next;

  logic                c_valid;
  logic                c_in_range;
  logic [CHANNEL_W-1:0] c_ch;
  logic [SUM_W-1:0]    c_sum;

  logic                d_valid;
  logic                d_in_range;
  logic [CHANNEL_W-1:0] d_ch;
  logic [PROD_W-1:0]   d_prod;

  out_t                out_item;
  logic                out_full;
  logic                popped;

  // issue only with a guaranteed slot in the output queue
  assign issue    = mid_valid && (occ < OCC_W'(OUT_DEPTH));
  assign mid_take = issue;
  assign popped   = pop && !empty;

  assign a_idx  = CH_IDX_W'(mid_item.channel);
  assign a_pos  = pos[a_idx];
  assign a_addr = ADDR_W'(a_idx) * ADDR_W'(WINDOW) + ADDR_W'(a_pos);

  always_ff @(posedge clk) begin
    if (issue) begin
      b_rdata <= mem[a_addr];
      if (mid_item.in_range) begin
        mem[a_addr] <= mid_item.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos[i]     <= '0;
        wrapped[i] <= 1'b0;
        sum[i]     <= '0;
      end
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      case ({issue, popped})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
      if (issue && mid_item.in_range) begin
        if (a_pos == POS_W'(WINDOW - 1)) begin
          pos[a_idx]     <= '0;
          wrapped[a_idx] <= 1'b1;
        end else begin
          pos[a_idx] <= a_pos + 1'b1;
        end
      end
      if (b_valid && b_in_range) begin
        sum[b_idx] <= sum_next;
      end
      b_valid <= issue;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // stage A -> B
  always_ff @(posedge clk) begin
    b_in_range  <= mid_item.in_range;
    b_old_valid <= wrapped[a_idx];
    b_ch        <= mid_item.channel;
    b_sample    <= mid_item.sample;
  end

  // unwritten ring entries read as zero until the channel wraps
  assign b_idx    = CH_IDX_W'(b_ch);
  assign b_old    = b_old_valid ? b_rdata : '0;
  assign sum_next = sum[b_idx] - SUM_W'(b_old) + SUM_W'(b_sample);

  always_ff @(posedge clk) begin
    c_in_range <= b_in_range;
    c_ch       <= b_ch;
    c_sum      <= sum_next;
  end

  // floor(sum / WINDOW) by reciprocal multiply
  always_ff @(posedge clk) begin
    d_in_range <= c_in_range;
    d_ch       <= c_ch;
    d_prod     <= PROD_W'(c_sum) * PROD_W'(RECIP);
  end

  always_comb begin
    out_item.channel_out = d_ch;
    out_item.average     = d_in_range ? d_prod[SHIFT +: SAMPLE_W] : '0;
  end

  mma_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (d_valid),
    .wr_data(out_item),
    .rd_en  (pop),
    .rd_data(result),
    .full   (out_full),
    .empty  (empty)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

// ===== rtl/multichannel_moving_average_core.sv =====
// Channel   Handshake     Payload
// -------   -----------   -------------------------------------------
// request   push / full   channel (3b), sample (12b)
// result    pop / empty   channel_out (3b), average (12b)
//
// One transaction per cycle sustained while the result side keeps up; a
// transaction passes through the input queue, ring store read, sum update,
// reciprocal multiply, output queue. The per-channel sum is updated in a
// single stage, so same-channel transactions follow back to back.
// Reset (rst, synchronous) clears queues, ring pointers and sums; no
// clearing pass over the ring store. A stalled result side fills the
// output queue, then the input queue, then raises full.
module multichannel_moving_average_core #(
  parameter int NUM_CHANNELS = mma_pkg::NUM_CHANNELS_DEFAULT,
  parameter int WINDOW       = mma_pkg::WINDOW_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mma_pkg::in_t  request,
  output logic          empty,
  input  logic          pop,
  output mma_pkg::out_t result
);

  import mma_pkg::*;

  mid_t mid_item;
  logic mid_valid;
  logic mid_take;

  mma_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .mid_item (mid_item),
    .mid_valid(mid_valid),
    .mid_take (mid_take)
  );

  mma_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .WINDOW      (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_item (mid_item),
    .mid_valid(mid_valid),
    .mid_take (mid_take),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// ===== dv/multichannel_moving_average_core_checker.sv =====
module multichannel_moving_average_core_checker
  import mma_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT,
  parameter int WINDOW       = WINDOW_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  in_t  request,
  input  logic empty,
  input  logic pop,
  input  out_t result,
  output int   mismatch_count,
  output int   outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [SAMPLE_W-1:0] ring [NUM_CHANNELS][WINDOW];
  logic [SUM_W-1:0]    window_sum [NUM_CHANNELS];
  int                  head [NUM_CHANNELS];
  out_t                expected_averages [$];

  function automatic out_t advance_window(in_t txn);
    out_t             avg;
    int               ch;
    logic [SUM_W-1:0] sum;
    ch              = txn.channel;
    avg.channel_out = txn.channel;
    avg.average     = '0;
    if (ch < NUM_CHANNELS) begin
      sum = window_sum[ch] - SUM_W'(ring[ch][head[ch]]) + SUM_W'(txn.sample);
      window_sum[ch]     = sum;
      ring[ch][head[ch]] = txn.sample;
      head[ch]           = (head[ch] + 1) % WINDOW;
      avg.average        = SAMPLE_W'(sum / WINDOW);
    end
    return avg;
  endfunction

  always @(posedge clk) begin
    out_t exp_avg;
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        window_sum[c] = '0;
        head[c]       = 0;
        for (int w = 0; w < WINDOW; w++) ring[c][w] = '0;
      end
      expected_averages.delete();
      mismatch_count = 0;
      outstanding    = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected result transaction: channel_out=%0d average=%0d",
                 result.channel_out, result.average);
          mismatch_count++;
        end else begin
          exp_avg = expected_averages.pop_front();
          if (result.channel_out !== exp_avg.channel_out) begin
            $error("channel_out mismatch: expected %0d, actual %0d",
                   exp_avg.channel_out, result.channel_out);
            mismatch_count++;
          end
          if (result.average !== exp_avg.average) begin
            $error("average mismatch: expected %0d, actual %0d",
                   exp_avg.average, result.average);
            mismatch_count++;
          end
        end
      end
      if (push && !full) expected_averages.push_back(advance_window(request));
      outstanding = expected_averages.size();
    end
  end

endmodule

// ===== dv/multichannel_moving_average_core_tb.sv =====
module multichannel_moving_average_core_tb;
  import mma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int HOLD_CYCLES      = 300;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic push    = 1'b0;
  logic pop     = 1'b0;
  in_t  request = '0;
  logic full;
  logic empty;
  out_t result;

  int             mismatch_count;
  int             outstanding;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_request  = 1'b0;
  logic [CHANNEL_W-1:0] last_channel = '0;

  always #5 clk = ~clk;

  multichannel_moving_average_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  multichannel_moving_average_core_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .request        (request),
    .empty          (empty),
    .pop            (pop),
    .result         (result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  task automatic send(logic [CHANNEL_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    request <= '{channel: ch, sample: smp};
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [CHANNEL_W-1:0] ch;
    logic [SAMPLE_W-1:0]  smp;
    int                   r;
    r = $urandom_range(99);
    if (r < 35) ch = last_channel;
    else if (r < 45) ch = CHANNEL_W'(6 + $urandom_range(1));
    else ch = CHANNEL_W'($urandom_range(NUM_CHANNELS_DEFAULT - 1));
    last_channel = ch;
    case ($urandom_range(9))
      0: begin
        smp = '0;
      end
      1: begin
        smp = '1;
      end
      default: begin
        smp = SAMPLE_W'($urandom);
      end
    endcase
    send(ch, smp);
  endtask

  // result side; a hold-off request stalls it long enough to back up the input
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full-scale window, then wrap of the ring
    repeat (9) send(3'd0, 12'hFFF);
    send(3'd6, 12'hFFF);
    send(3'd7, 12'hABC);
    send(3'd1, 12'h000);
    send(3'd5, 12'hFFF);
    send(3'd5, 12'h001);
    send(3'd5, 12'hFFF);
    send(3'd2, 12'h001);
    send(3'd3, 12'h800);
    send(3'd4, 12'h7FF);
    send(3'd0, 12'h000);
    send(3'd0, 12'h000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 55;
          hold_request  = 1'b1;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
    end
    push <= 1'b0;

    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multichannel_moving_average_core test passed");
    end else begin
      $display("multichannel_moving_average_core test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("multichannel_moving_average_core test failed");
    $finish;
  end

endmodule
